// File: rtl/lzgc_pkg.sv
// ----------------------------------------------------------------------------
// lzgc_pkg
// Shared types and constants of the greedy LZ77 compressor.
// ----------------------------------------------------------------------------
package lzgc_pkg;

    localparam int WINDOW_DEPTH     = 1024;
    localparam int MIN_MATCH_LENGTH = 3;
    localparam int REPLAY_DEPTH     = MIN_MATCH_LENGTH - 1;
    localparam int OFF_W            = 11;
    localparam int LEN_W            = 16;
    localparam int CNT_W            = 2;
    localparam logic [LEN_W-1:0] MAX_MATCH_LENGTH = 16'hFFFF;

    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } lzgc_item_t;

    typedef struct packed {
        logic             last;
        logic [7:0]       following;
        logic [LEN_W-1:0] length;
        logic [OFF_W-1:0] offset;
    } lzgc_token_t;

endpackage

// File: rtl/lzgc_in_queue.sv
// ----------------------------------------------------------------------------
// lzgc_in_queue
// Two-entry input queue that decouples the stream slave from the matcher.
// ----------------------------------------------------------------------------
module lzgc_in_queue
    import lzgc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // data_byte
    input  logic       s_tlast,   // end_of_stream
    output logic       head_valid,
    output lzgc_item_t head_item,
    input  logic       head_pop
);

    lzgc_item_t  slot_reg [2];
    logic [1:0]  count_reg;
    logic        rd_reg;
    logic        wr_reg;
    logic        push;

    assign s_tready   = (count_reg != 2'd2);
    assign push       = s_tvalid && s_tready;
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = slot_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
            rd_reg    <= 1'b0;
            wr_reg    <= 1'b0;
        end else begin
            if (push) begin
                wr_reg <= ~wr_reg;
            end
            if (head_pop && head_valid) begin
                rd_reg <= ~rd_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, head_pop && head_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_reg] <= '{last: s_tlast, data: s_tdata};
        end
    end

endmodule

// File: rtl/lzgc_matcher.sv
// ----------------------------------------------------------------------------
// lzgc_matcher
// Parallel match engine over a shifting history window, with replay of short
// runs and a registered token output.
// ----------------------------------------------------------------------------
module lzgc_matcher
    import lzgc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        head_valid,
    input  lzgc_item_t  head_item,
    output logic        head_pop,
    output logic        tok_valid,
    input  logic        tok_ready,
    output lzgc_token_t tok
);

    logic [7:0]        hist_reg [WINDOW_DEPTH];
    logic [7:0]        hist_next [WINDOW_DEPTH];
    logic [7:0]        rep_reg [REPLAY_DEPTH];
    logic [7:0]        pend_reg [REPLAY_DEPTH];
    logic [CNT_W-1:0]  pend_cnt_reg;
    logic [CNT_W-1:0]  rc_reg;
    logic [OFF_W-1:0]  fill_reg;
    logic [WINDOW_DEPTH-1:0] alive_reg;
    logic [WINDOW_DEPTH-1:0] hit;
    logic [LEN_W-1:0]  len_reg;
    logic [OFF_W-1:0]  best_reg;
    logic              flush_reg;
    logic [7:0]        flush_byte_reg;
    logic              out_valid_reg;
    lzgc_token_t       out_tok_reg;

    logic              src_valid;
    logic [7:0]        x;
    logic              fin;
    logic              step;
    logic              any_hit;
    logic [OFF_W-1:0]  top;
    logic [LEN_W-1:0]  len_inc;
    logic [1:0]        commit_cnt;
    logic [7:0]        cb [3];
    logic [OFF_W+1:0]  fill_sum;

    assign src_valid = (pend_cnt_reg != '0) || head_valid;
    assign x         = (pend_cnt_reg != '0) ? pend_reg[0] : head_item.data;
    assign fin       = (pend_cnt_reg != '0) ? 1'b0 : head_item.last;
    assign step      = src_valid && !flush_reg && (!out_valid_reg || tok_ready);
    assign len_inc   = len_reg + 1'b1;

    for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_tap
        logic [7:0] h1, h2, bb;
        if (g == 0) begin : g_first
            assign h1 = rep_reg[0];
            assign h2 = rep_reg[1];
            assign hist_next[g] = (commit_cnt == 2'd0) ? hist_reg[g] : cb[0];
        end else if (g == 1) begin : g_second
            assign h1 = hist_reg[0];
            assign h2 = rep_reg[0];
            assign hist_next[g] = (commit_cnt == 2'd0) ? hist_reg[g] :
                                  (commit_cnt == 2'd1) ? hist_reg[0] : cb[1];
        end else begin : g_rest
            logic [7:0] s2, s3;
            assign h1 = hist_reg[g-1];
            assign h2 = hist_reg[g-2];
            assign s2 = hist_reg[g-2];
            if (g == 2) begin : g_third
                assign s3 = cb[2];
            end else begin : g_deep
                assign s3 = hist_reg[g-3];
            end
            assign hist_next[g] = (commit_cnt == 2'd0) ? hist_reg[g]   :
                                  (commit_cnt == 2'd1) ? hist_reg[g-1] :
                                  (commit_cnt == 2'd2) ? s2 : s3;
        end
        assign bb = (rc_reg == 2'd1) ? h1 : (rc_reg == 2'd2) ? h2 : hist_reg[g];
        assign hit[g] = ((len_reg == '0) ? (OFF_W'(g) < fill_reg) : alive_reg[g])
                        && (bb == x);
    end

    always_comb begin
        top = '0;
        for (int j = 0; j < WINDOW_DEPTH; j++) begin
            if (hit[j]) begin
                top = OFF_W'(j + 1);
            end
        end
    end

    assign any_hit  = |hit;
    assign fill_sum = {2'b00, fill_reg} + {{OFF_W{1'b0}}, commit_cnt};

    always_comb begin
        commit_cnt = 2'd0;
        cb[0] = x;
        cb[1] = (rc_reg == 2'd2) ? rep_reg[1] : rep_reg[0];
        cb[2] = rep_reg[0];
        if (step) begin
            if (len_reg >= MAX_MATCH_LENGTH) begin
                commit_cnt = 2'd1;
            end else if (any_hit) begin
                if (len_inc >= LEN_W'(MIN_MATCH_LENGTH)) begin
                    commit_cnt = rc_reg + 2'd1;
                end
            end else if (len_reg >= LEN_W'(MIN_MATCH_LENGTH) || len_reg == '0) begin
                commit_cnt = 2'd1;
            end else begin
                commit_cnt = 2'd1;
                cb[0] = rep_reg[0];
            end
        end
    end

    always_comb begin
        head_pop = 1'b0;
        if (step && (pend_cnt_reg == '0)) begin
            head_pop = (len_reg >= MAX_MATCH_LENGTH) || any_hit ||
                       (len_reg >= LEN_W'(MIN_MATCH_LENGTH)) || (len_reg == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (commit_cnt != 2'd0) begin
            hist_reg <= hist_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_cnt_reg  <= '0;
            rc_reg        <= '0;
            fill_reg      <= '0;
            alive_reg     <= '0;
            len_reg       <= '0;
            best_reg      <= '0;
            flush_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (tok_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (flush_reg && (!out_valid_reg || tok_ready)) begin
                flush_reg     <= 1'b0;
                out_valid_reg <= 1'b1;
                out_tok_reg   <= '{last: 1'b1, following: flush_byte_reg,
                                   length: '0, offset: '0};
            end
            if (step) begin
                if (fill_sum > (OFF_W+2)'(WINDOW_DEPTH)) begin
                    fill_reg <= OFF_W'(WINDOW_DEPTH);
                end else begin
                    fill_reg <= fill_sum[OFF_W-1:0];
                end
                if (pend_cnt_reg != '0 && head_pop == 1'b0 &&
                    ((len_reg >= MAX_MATCH_LENGTH) || any_hit ||
                     (len_reg >= LEN_W'(MIN_MATCH_LENGTH)) || (len_reg == '0))) begin
                    pend_reg[0]  <= pend_reg[1];
                    pend_cnt_reg <= pend_cnt_reg - 1'b1;
                end
                if (len_reg >= MAX_MATCH_LENGTH) begin
                    out_valid_reg <= 1'b1;
                    out_tok_reg   <= '{last: fin, following: x, length: len_reg,
                                       offset: best_reg};
                    len_reg   <= '0;
                    best_reg  <= '0;
                    rc_reg    <= '0;
                    alive_reg <= '0;
                end else if (any_hit) begin
                    len_reg   <= len_inc;
                    best_reg  <= top;
                    alive_reg <= hit;
                    if (len_inc < LEN_W'(MIN_MATCH_LENGTH)) begin
                        rep_reg[rc_reg[0]] <= x;
                        rc_reg <= rc_reg + 1'b1;
                    end else begin
                        rc_reg <= '0;
                    end
                    if (fin) begin
                        out_valid_reg <= 1'b1;
                        len_reg   <= '0;
                        best_reg  <= '0;
                        rc_reg    <= '0;
                        alive_reg <= '0;
                        if (len_inc >= LEN_W'(MIN_MATCH_LENGTH)) begin
                            out_tok_reg <= '{last: 1'b1, following: 8'h00,
                                             length: len_inc, offset: top};
                        end else if (rc_reg == '0) begin
                            out_tok_reg <= '{last: 1'b1, following: x,
                                             length: '0, offset: '0};
                        end else begin
                            out_tok_reg <= '{last: 1'b0, following: rep_reg[0],
                                             length: '0, offset: '0};
                            flush_reg      <= 1'b1;
                            flush_byte_reg <= x;
                        end
                    end
                end else if (len_reg >= LEN_W'(MIN_MATCH_LENGTH)) begin
                    out_valid_reg <= 1'b1;
                    out_tok_reg   <= '{last: fin, following: x, length: len_reg,
                                       offset: best_reg};
                    len_reg   <= '0;
                    best_reg  <= '0;
                    rc_reg    <= '0;
                    alive_reg <= '0;
                end else if (len_reg == '0) begin
                    out_valid_reg <= 1'b1;
                    out_tok_reg   <= '{last: fin, following: x, length: '0, offset: '0};
                    rc_reg    <= '0;
                    alive_reg <= '0;
                end else begin
                    out_valid_reg <= 1'b1;
                    out_tok_reg   <= '{last: 1'b0, following: rep_reg[0],
                                       length: '0, offset: '0};
                    len_reg   <= '0;
                    best_reg  <= '0;
                    rc_reg    <= '0;
                    alive_reg <= '0;
                    if (rc_reg == 2'd2) begin
                        pend_reg[0]  <= rep_reg[1];
                        pend_reg[1]  <= pend_reg[0];
                        pend_cnt_reg <= pend_cnt_reg + 1'b1;
                    end
                end
                if (fin && ((len_reg >= MAX_MATCH_LENGTH) || any_hit ||
                            (len_reg >= LEN_W'(MIN_MATCH_LENGTH)) || (len_reg == '0))) begin
                    fill_reg <= '0;
                end
            end
        end
    end

    assign tok_valid = out_valid_reg;
    assign tok       = out_tok_reg;

endmodule

// File: rtl/lz77_greedy_compressor.sv
// An accepted byte waits in the input queue; its token is written to the output register.
// Throughput: one byte per cycle unless the output stalls; a failed short match replays
// the bytes of its run, and a stream ending inside a two-byte run adds a flush token.
// The rate is set by the combinational compare of all 1024 window taps.
// Reset is synchronous and active low; it clears all control state and marks the
// window empty, leaving its contents in place.
// ----------------------------------------------------------------------------
// lz77_greedy_compressor
// Greedy LZ77 compressor with a 1024-byte window, one byte per transfer.
// ----------------------------------------------------------------------------
module lz77_greedy_compressor
    import lzgc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,   // end_of_stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // match_offset, match_length, following_byte, zero fill
    output logic        m_tlast    // final_token
);

    logic        head_valid;
    lzgc_item_t  head_item;
    logic        head_pop;
    lzgc_token_t tok;

    lzgc_in_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .head_valid (head_valid),
        .head_item  (head_item),
        .head_pop   (head_pop)
    );

    lzgc_matcher u_matcher (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_item  (head_item),
        .head_pop   (head_pop),
        .tok_valid  (m_tvalid),
        .tok_ready  (m_tready),
        .tok        (tok)
    );

    assign m_tdata = {5'b00000, tok.following, tok.length, tok.offset};
    assign m_tlast = tok.last;

endmodule

// File: rtl/lzgc_checker.sv
// ----------------------------------------------------------------------------
// lzgc_checker
// Port-level checks of the compressor's token stream.
// ----------------------------------------------------------------------------
module lzgc_checker
    import lzgc_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("token changed while stalled");

    a_literal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[10:0] == 11'd0) == (m_tdata[26:11] == 16'd0)))
        else $error("offset and length disagree on literal");

    a_minlen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[26:11] != 16'd0) |-> m_tdata[26:11] >= 16'd3)
        else $error("match shorter than minimum");

    a_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[10:0] <= 11'd1024)
        else $error("offset beyond window");

endmodule

bind lz77_greedy_compressor lzgc_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the greedy LZ77 compressor. A byte-level predictor
// keeps its own window and candidate set, computes the tokens each accepted
// byte causes, and compares them in order with the tokens on the result side.
// ----------------------------------------------------------------------------
module testbench;
    import lzgc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEN = 65535;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;

    lz77_greedy_compressor dut (.*);

    always #10 aclk = ~aclk;

    lzgc_item_t  byte_queue[$];
    lzgc_token_t token_queue[$];
    int          mismatch_count = 0;
    int          hold_off = 0;
    bit          in_taken = 1'b0;

    // Predictor state.
    logic [7:0]  win_mem[WINDOW_DEPTH];
    int          win_fill;
    int          win_wr;
    bit          alive[WINDOW_DEPTH + 1];
    int          run_len;
    int          run_off;
    logic [7:0]  replay_mem[MIN_MATCH_LENGTH];
    int          replay_cnt;

    function automatic void put_token(int off, int len, int b, bit fin);
        lzgc_token_t t;
        t.offset    = off[OFF_W-1:0];
        t.length    = len[LEN_W-1:0];
        t.following = b[7:0];
        t.last      = fin;
        token_queue.push_back(t);
    endfunction

    function automatic void window_push(logic [7:0] b);
        win_mem[win_wr] = b;
        win_wr = (win_wr + 1) % WINDOW_DEPTH;
        if (win_fill < WINDOW_DEPTH) win_fill++;
    endfunction

    function automatic logic [7:0] look_back(int d);
        if (d <= replay_cnt) return replay_mem[replay_cnt - d];
        return win_mem[(win_wr + WINDOW_DEPTH - (d - replay_cnt)) % WINDOW_DEPTH];
    endfunction

    function automatic void run_reset();
        run_len = 0;
        run_off = 0;
        replay_cnt = 0;
        foreach (alive[i]) alive[i] = 1'b0;
    endfunction

    function automatic void stream_reset();
        win_fill = 0;
        win_wr = 0;
        run_reset();
    endfunction

    function automatic void match_byte(logic [7:0] x, bit fin);
        int top;
        bit any;
        bit m;
        int n;
        logic [7:0] held[MIN_MATCH_LENGTH];
        top = 0;
        any = 1'b0;
        if (run_len >= MAX_LEN) begin
            put_token(run_off, run_len, x, fin);
            window_push(x);
            run_reset();
            return;
        end
        for (int d = 1; d <= WINDOW_DEPTH; d++) begin
            if (run_len == 0) m = (d <= win_fill) && look_back(d) == x;
            else m = alive[d] && look_back(d) == x;
            alive[d] = m;
            if (m) begin
                any = 1'b1;
                top = d;
            end
        end
        if (any) begin
            run_len++;
            run_off = top;
            if (run_len < MIN_MATCH_LENGTH) begin
                replay_mem[replay_cnt++] = x;
            end else begin
                for (int k = 0; k < replay_cnt; k++) window_push(replay_mem[k]);
                replay_cnt = 0;
                window_push(x);
            end
            if (fin) begin
                if (run_len >= MIN_MATCH_LENGTH) begin
                    put_token(run_off, run_len, 0, 1'b1);
                end else begin
                    for (int k = 0; k < replay_cnt; k++)
                        put_token(0, 0, replay_mem[k], k + 1 == replay_cnt);
                end
                run_reset();
            end
            return;
        end
        if (run_len >= MIN_MATCH_LENGTH) begin
            put_token(run_off, run_len, x, fin);
            window_push(x);
            run_reset();
            return;
        end
        if (run_len == 0) begin
            put_token(0, 0, x, fin);
            window_push(x);
            run_reset();
            return;
        end
        n = replay_cnt;
        for (int k = 0; k < n; k++) held[k] = replay_mem[k];
        put_token(0, 0, held[0], 1'b0);
        window_push(held[0]);
        run_reset();
        for (int k = 1; k < n; k++) match_byte(held[k], 1'b0);
        match_byte(x, fin);
    endfunction

    function automatic void add_byte(int b, bit fin);
        lzgc_item_t it;
        it.data = b[7:0];
        it.last = fin;
        byte_queue.push_back(it);
    endfunction

    always @(posedge aclk) begin
        in_taken <= s_tvalid && s_tready;
    end

    // Driver: one item per transfer, random gap after each.
    int send_gap = 0;
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !in_taken) begin
        end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            s_tvalid <= 1'b0;
        end else if (byte_queue.size() > 0) begin
            s_tvalid <= 1'b1;
            s_tdata <= byte_queue[0].data;
            s_tlast <= byte_queue[0].last;
            void'(byte_queue.pop_front());
            send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Predict on the accepted byte; the final byte of a stream empties the window.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            match_byte(s_tdata, s_tlast);
            if (s_tlast) stream_reset();
        end
    end

    int recv_gap = 0;
    always @(negedge aclk) begin
        if (hold_off > 0) begin
            m_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (m_tvalid) recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
        end
    end

    always @(posedge aclk) begin
        if (hold_off > 0) hold_off <= hold_off - 1;
    end

    // Monitor.
    always @(posedge aclk) begin
        lzgc_token_t got;
        lzgc_token_t exp_t;
        if (aresetn && m_tvalid && m_tready) begin
            got.offset    = m_tdata[10:0];
            got.length    = m_tdata[26:11];
            got.following = m_tdata[34:27];
            got.last      = m_tlast;
            if (token_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected token off=%0d len=%0d byte=%0h last=%0b",
                             got.offset, got.length, got.following, got.last);
            end else begin
                exp_t = token_queue.pop_front();
                if (got !== exp_t) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("token mismatch exp off=%0d len=%0d byte=%0h last=%0b",
                                 exp_t.offset, exp_t.length, exp_t.following, exp_t.last,
                                 ", got off=%0d len=%0d byte=%0h last=%0b",
                                 got.offset, got.length, got.following, got.last);
                end
            end
        end
    end

    task automatic add_stream(int len);
        int mode;
        int alpha;
        mode = $urandom_range(0, 3);
        alpha = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) begin
            int b;
            case (mode)
                0: b = $urandom_range(0, 255);
                1: b = $urandom_range(0, alpha);
                2: b = (i % (alpha + 1)) * 37 + 200;
                default: b = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                        : 8'h55 ^ (i % 3);
            endcase
            add_byte(b, i == len - 1);
        end
    endtask

    task automatic cycle_wait();
        @(posedge aclk);
    endtask

    initial begin
        stream_reset();
        foreach (win_mem[i]) win_mem[i] = 8'h00;
        // Single byte stream, then two streams ending inside a short run, then a
        // failed short run with replay.
        add_byte(8'h00, 1'b1);
        add_byte(8'hFF, 1'b0); add_byte(8'hFF, 1'b1);
        add_byte(8'hAA, 1'b0); add_byte(8'hAA, 1'b0); add_byte(8'hAA, 1'b1);
        add_byte(8'h01, 1'b0); add_byte(8'h02, 1'b0); add_byte(8'h01, 1'b0);
        add_byte(8'h02, 1'b0); add_byte(8'h03, 1'b0);
        add_byte(8'h01, 1'b0); add_byte(8'h02, 1'b0); add_byte(8'h03, 1'b0);
        add_byte(8'h80, 1'b0); add_byte(8'h7F, 1'b1);
        repeat (3) cycle_wait();
        @(negedge aclk);
        aresetn = 1'b1;
        while (byte_queue.size() > 0 || s_tvalid) cycle_wait();
        add_stream(220);
        hold_off = 200;
        while (byte_queue.size() > 0 || s_tvalid) cycle_wait();
        while (byte_queue.size() + 0 < 1 && token_queue.size() > 0) cycle_wait();
        for (int n = 0; n < 30; n++) add_stream($urandom_range(1, 12));
        while (byte_queue.size() > 0 || s_tvalid) cycle_wait();
        while (token_queue.size() > 0) cycle_wait();
        repeat (20) cycle_wait();
        if (mismatch_count == 0 && token_queue.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial begin
        #5ms;
        $display("testbench: errors");
        $finish;
    end
endmodule
